@@ rtl/uart_register_datagram_framer_assert.svh @@
// Assertion macros for the datagram framer top level.
`ifndef UART_REGISTER_DATAGRAM_FRAMER_ASSERT_SVH
`define UART_REGISTER_DATAGRAM_FRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define URDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define URDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/urdf_pkg.sv @@
// Package for the datagram framer: types, constants and the CRC-8 step.
package urdf_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE = 2'd1;

  localparam logic [7:0] NODE_ADDRESS_RESET = 8'h00;
  localparam logic [7:0] SYNC_BYTE_RESET = 8'h05;
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam logic ACTION_READ = 1'b0;
  localparam logic ACTION_WRITE = 1'b1;

  // Byte positions within a datagram.
  localparam logic [2:0] POS_SYNC = 3'd0;
  localparam logic [2:0] POS_NODE = 3'd1;
  localparam logic [2:0] POS_ADDR = 3'd2;
  localparam logic [2:0] POS_DATA3 = 3'd3;
  localparam logic [2:0] POS_DATA2 = 3'd4;
  localparam logic [2:0] POS_DATA1 = 3'd5;
  localparam logic [2:0] POS_DATA0 = 3'd6;
  localparam logic [2:0] WRITE_LAST_POS = 3'd7;
  localparam logic [2:0] READ_LAST_POS = 3'd3;

  typedef struct packed {
    logic        action;
    logic [6:0]  register_address;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } res_t;

  // One classified request, waiting in the queue for the serializer.
  typedef struct packed {
    logic        is_write;
    logic [7:0]  sync_byte;
    logic [7:0]  node_address;
    logic [7:0]  addr_byte;
    logic [31:0] data;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Feeds one byte into the CRC, least significant bit first.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] b;
    logic       fb;
    c = crc;
    b = data;
    for (int k = 0; k < 8; k++) begin
      fb = c[7] ^ b[0];
      c = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      b = {1'b0, b[7:1]};
    end
    return c;
  endfunction

endpackage

@@ rtl/urdf_front.sv @@
// Front end: configuration registers and request classification.
module urdf_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  urdf_pkg::req_t                   request,
  input  urdf_pkg::q_stat_t                q_stat,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [urdf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [urdf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             busy,
  output logic                             push,
  output urdf_pkg::frame_t                 push_frame
);
  import urdf_pkg::*;

  logic [7:0] node_address;
  logic [7:0] sync_byte;

  assign cfg_ready = 1'b1;
  assign busy = q_stat.full;
  assign push = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= NODE_ADDRESS_RESET;
      sync_byte <= SYNC_BYTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NODE_ADDRESS) begin
        node_address <= cfg_data;
      end else if (cfg_index == REG_SYNC_BYTE) begin
        sync_byte <= cfg_data;
      end
    end
  end

  // Address bit 7 carries the direction: set for writes, clear for reads.
  always_comb begin
    push_frame.is_write = (request.action == ACTION_WRITE);
    push_frame.sync_byte = sync_byte;
    push_frame.node_address = node_address;
    push_frame.addr_byte = {request.action, request.register_address};
    push_frame.data = request.write_value;
  end

endmodule

@@ rtl/urdf_queue.sv @@
// Short queue of classified requests between front end and serializer.
module urdf_queue #(
  parameter int DEPTH = urdf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  urdf_pkg::frame_t  push_frame,
  input  logic              pop,
  output urdf_pkg::frame_t  pop_frame,
  output urdf_pkg::q_stat_t q_stat
);
  import urdf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  frame_t           entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_stat.empty = (count == '0);
  assign q_stat.full = (count == CNT_W'(DEPTH));
  assign do_push = push && !q_stat.full;
  assign do_pop = pop && !q_stat.empty;
  assign pop_frame = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/urdf_back.sv @@
// Back end: serializes one datagram a byte per cycle and appends the CRC.
module urdf_back (
  input  logic              clk,
  input  logic              rst,
  input  urdf_pkg::q_stat_t q_stat,
  input  urdf_pkg::frame_t  pop_frame,
  output logic              pop,
  output logic              result_valid,
  output urdf_pkg::res_t    result
);
  import urdf_pkg::*;

  logic       active;
  logic [2:0] pos;
  frame_t     cur;
  logic [7:0] crc;
  logic [2:0] last_pos;
  logic       is_last;
  logic [7:0] byte_sel;

  assign last_pos = cur.is_write ? WRITE_LAST_POS : READ_LAST_POS;
  assign is_last = active && (pos == last_pos);
  // The next datagram is loaded in the cycle its predecessor's CRC byte is selected.
  assign pop = !q_stat.empty && (!active || is_last);

  always_comb begin
    case (pos)
      POS_SYNC:  byte_sel = cur.sync_byte;
      POS_NODE:  byte_sel = cur.node_address;
      POS_ADDR:  byte_sel = cur.addr_byte;
      POS_DATA3: byte_sel = cur.data[31:24];
      POS_DATA2: byte_sel = cur.data[23:16];
      POS_DATA1: byte_sel = cur.data[15:8];
      POS_DATA0: byte_sel = cur.data[7:0];
      default:   byte_sel = crc;
    endcase
    if (is_last) begin
      byte_sel = crc;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      result.frame_byte <= byte_sel;
      result.last_byte <= is_last;
    end
    if (pop) begin
      cur <= pop_frame;
      pos <= POS_SYNC;
      crc <= CRC_INIT;
    end else if (active) begin
      crc <= crc_feed(crc, byte_sel);
      pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (is_last) begin
        active <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/uart_register_datagram_framer.sv @@
// Top level of the UART register datagram framer.
// A request passes through a queue entry, the serializer's frame register and the result
// register before its first byte appears. Throughput: one byte per cycle from the serializer;
// a write datagram has 8 bytes and a read 4, and datagrams follow each other without gaps
// while the queue holds requests. busy is high while the request queue is full. Synchronous
// reset empties the queue and serializer and restores node address 0 and sync byte 5.
`include "uart_register_datagram_framer_assert.svh"

module uart_register_datagram_framer #(
  parameter int QUEUE_DEPTH = urdf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  urdf_pkg::req_t                   request,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [urdf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [urdf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             result_valid,
  output urdf_pkg::res_t                   result
);
  import urdf_pkg::*;

  q_stat_t q_stat;
  logic    push;
  frame_t  push_frame;
  logic    pop;
  frame_t  pop_frame;

  urdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .request    (request),
    .q_stat     (q_stat),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy       (busy),
    .push       (push),
    .push_frame (push_frame)
  );

  urdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .q_stat     (q_stat)
  );

  urdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .pop_frame    (pop_frame),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  // A taken request must be waiting in the queue or already loaded.
  `URDF_ASSERT_NEXT(a_push_lands, push, !q_stat.empty || u_back.active, "request lost")
  // Bytes of one datagram go out in consecutive cycles.
  `URDF_ASSERT_NEXT(a_contiguous, result_valid && !result.last_byte, result_valid,
                    "gap inside datagram")
  // The serializer never pulls from an empty queue.
  `URDF_ASSERT_NOW(a_no_underflow, pop, !q_stat.empty, "pop from empty queue")

endmodule

@@ tb/tb_uart_register_datagram_framer.sv @@
// Self-checking testbench for the UART register datagram framer.
`timescale 1ns / 100ps

module tb_uart_register_datagram_framer;
  import urdf_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 52;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    req_t                   req;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [7:0]             reg_value;
    bit                     known;
    logic [7:0]             known_bytes [4];
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic result_valid;
  res_t result;

  // Register copies used to predict each datagram.
  logic [7:0] cur_node;
  logic [7:0] cur_sync;
  res_t expected_bytes [$];
  int mismatch_count = 0;
  bit pauses_on;

  uart_register_datagram_framer dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic feedback;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      feedback = c[7] ^ data[k];
      c = {c[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // Appends the bytes of the datagram that a request should produce.
  function automatic void predict_datagram(input req_t r);
    logic [7:0] dgram [8];
    logic [7:0] crc;
    int len;
    dgram[0] = cur_sync;
    dgram[1] = cur_node;
    if (r.action == ACTION_WRITE) begin
      dgram[2] = {1'b1, r.register_address};
      dgram[3] = r.write_value[31:24];
      dgram[4] = r.write_value[23:16];
      dgram[5] = r.write_value[15:8];
      dgram[6] = r.write_value[7:0];
      len = 8;
    end else begin
      dgram[2] = {1'b0, r.register_address};
      len = 4;
    end
    crc = CRC_INIT;
    for (int i = 0; i < len - 1; i++) begin
      crc = crc8_step(crc, dgram[i]);
    end
    dgram[len - 1] = crc;
    for (int i = 0; i < len; i++) begin
      expected_bytes.push_back(res_t'{frame_byte: dgram[i], last_byte: (i == len - 1)});
    end
  endfunction

  function automatic dir_row_t req_row(input logic act, input logic [6:0] addr,
                                       input logic [31:0] value);
    dir_row_t row;
    row.kind = ROW_REQUEST;
    row.req = '{action: act, register_address: addr, write_value: value};
    row.reg_index = REG_NODE_ADDRESS;
    row.reg_value = '0;
    row.known = 1'b0;
    row.known_bytes = '{default: 8'h00};
    return row;
  endfunction

  function automatic dir_row_t known_read_row(input logic [6:0] addr, input logic [7:0] b0,
                                              input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3);
    dir_row_t row;
    row = req_row(ACTION_READ, addr, '0);
    row.known = 1'b1;
    row.known_bytes = '{b0, b1, b2, b3};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    dir_row_t row;
    row = req_row(ACTION_READ, '0, '0);
    row.kind = ROW_CONFIG;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.action = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: r.register_address = '0;
      1: r.register_address = '1;
      default: r.register_address = 7'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: r.write_value = '0;
      1: r.write_value = '1;
      default: r.write_value = $urandom;
    endcase
    return r;
  endfunction

  // Holds the request until the framer accepts it into the queue.
  task automatic send_request(input req_t r);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_pause();
    if (pauses_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Registers change only once every datagram in flight has been sent.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    if (pauses_on && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NODE_ADDRESS: cur_node = value;
      REG_SYNC_BYTE: cur_sync = value;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && result_valid) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %02h last %0b",
                 $realtime, result.frame_byte, result.last_byte);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (result.frame_byte !== want.frame_byte) begin
          $display("%0t: frame_byte expected %02h, got %02h",
                   $realtime, want.frame_byte, result.frame_byte);
          mismatch_count++;
        end
        if (result.last_byte !== want.last_byte) begin
          $display("%0t: last_byte expected %0b, got %0b",
                   $realtime, want.last_byte, result.last_byte);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    dir_row_t directed_rows [$];
    req_t r;
    int n_writes;

    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_node = NODE_ADDRESS_RESET;
    cur_sync = SYNC_BYTE_RESET;
    pauses_on = 1'b1;

    // After reset: sync 05, node 00, read of register 00.
    directed_rows.push_back(known_read_row(7'h00, 8'h05, 8'h00, 8'h00, 8'h48));
    directed_rows.push_back(req_row(ACTION_WRITE, 7'h00, 32'h0000_0000));
    directed_rows.push_back(req_row(ACTION_WRITE, 7'h7F, 32'hFFFF_FFFF));
    // A read ignores its data, and a write sets address bit 7.
    directed_rows.push_back(req_row(ACTION_READ, 7'h7F, 32'hFFFF_FFFF));
    directed_rows.push_back(req_row(ACTION_READ, 7'h55, 32'h1234_5678));
    directed_rows.push_back(req_row(ACTION_WRITE, 7'h2A, 32'h8000_0001));
    directed_rows.push_back(cfg_row(REG_NODE_ADDRESS, 8'hFF));
    directed_rows.push_back(cfg_row(REG_SYNC_BYTE, 8'hFF));
    directed_rows.push_back(req_row(ACTION_WRITE, 7'h7F, 32'hFFFF_FFFF));
    directed_rows.push_back(req_row(ACTION_READ, 7'h00, 32'h0000_0000));
    // Writes to unused register indexes must leave both registers alone.
    directed_rows.push_back(cfg_row(REG_UNUSED_2, 8'h00));
    directed_rows.push_back(cfg_row(REG_UNUSED_3, 8'h00));
    directed_rows.push_back(req_row(ACTION_READ, 7'h33, 32'hAAAA_AAAA));
    directed_rows.push_back(cfg_row(REG_NODE_ADDRESS, 8'h00));
    directed_rows.push_back(cfg_row(REG_SYNC_BYTE, 8'h00));
    // An all-zero datagram has a zero CRC.
    directed_rows.push_back(known_read_row(7'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(req_row(ACTION_WRITE, 7'h00, 32'h0000_0000));
    directed_rows.push_back(req_row(ACTION_WRITE, 7'h55, 32'hAAAA_AAAA));
    directed_rows.push_back(req_row(ACTION_WRITE, 7'h2A, 32'h5555_5555));
    directed_rows.push_back(cfg_row(REG_SYNC_BYTE, 8'h05));
    directed_rows.push_back(cfg_row(REG_NODE_ADDRESS, 8'h17));
    directed_rows.push_back(req_row(ACTION_WRITE, 7'h01, 32'h0102_0304));
    directed_rows.push_back(req_row(ACTION_READ, 7'h40, 32'h0000_0000));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        wait_idle();
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_request(directed_rows[i].req);
        if (directed_rows[i].known) begin
          for (int k = 0; k < 4; k++) begin
            expected_bytes.push_back(res_t'{frame_byte: directed_rows[i].known_bytes[k],
                                            last_byte: (k == 3)});
          end
        end else begin
          predict_datagram(directed_rows[i].req);
        end
        maybe_pause();
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // The final phase runs at full rate; earlier phases may run without gaps too.
      pauses_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      wait_idle();
      n_writes = $urandom_range(1, 3);
      for (int w = 0; w < n_writes; w++) begin
        if (w > 0) begin
          wait_idle();
        end
        case ($urandom_range(0, 3))
          0: write_register(CFG_INDEX_W'($urandom_range(0, 3)), 8'h00);
          1: write_register(CFG_INDEX_W'($urandom_range(0, 3)), 8'hFF);
          default: write_register(CFG_INDEX_W'($urandom_range(0, 3)), 8'($urandom));
        endcase
      end
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        r = random_request();
        send_request(r);
        predict_datagram(r);
        maybe_pause();
      end
    end

    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/urdf_pkg.sv
rtl/urdf_front.sv
rtl/urdf_queue.sv
rtl/urdf_back.sv
rtl/uart_register_datagram_framer.sv
tb/tb_uart_register_datagram_framer.sv
